// ----- rtl/core/efp_pkg.sv -----
package efp_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_HEADER_BYTE   = 3'd0;
   localparam logic [2:0] REG_INIT_BYTE     = 3'd1;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
   localparam logic [2:0] REG_FILL_LENGTH   = 3'd3;
   localparam logic [2:0] REG_AMP_GAIN      = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // reset values of the configuration registers
   localparam logic [7:0]  RST_HEADER_BYTE   = 8'd160;
   localparam logic [7:0]  RST_INIT_BYTE     = 8'd36;
   localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd8;
   localparam logic [15:0] RST_FILL_LENGTH   = 16'd256;
   localparam logic [4:0]  RST_AMP_GAIN      = 5'd24;

   // frame parser phases
   localparam logic [1:0] PHASE_HUNT   = 2'd0;
   localparam logic [1:0] PHASE_SKIP   = 2'd1;
   localparam logic [1:0] PHASE_SAMPLE = 2'd2;

   localparam logic [16:0] FRAME_COUNT_MAX = 17'h1FFFF;

   // scaling arithmetic
   localparam int SCALE_NUM  = 450;
   localparam int FULL_SCALE = 8388607;
   localparam int NUM_W      = 32;                 // |raw| * 450 fits in 32 bits
   localparam int PROD_W     = 28;                 // gain * full scale
   localparam int QUOT_W     = 9;                  // quotient never exceeds 450
   localparam int DEN_W      = PROD_W + QUOT_W - 1;
   localparam int STEP_W     = $clog2(QUOT_W);

   typedef struct packed {
      logic accept;
      logic start_mul;
      logic div_step;
      logic load_out;
   } efp_cmd_type;

   typedef struct packed {
      logic sample_now;
      logic out_free;
   } efp_stat_type;

endpackage

// ----- rtl/core/efp_ctrl.sv -----
module efp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  efp_pkg::efp_stat_type stat,
   output efp_pkg::efp_cmd_type  cmd
);
   import efp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd.accept    = 1'b0;
      cmd.start_mul = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.sample_now) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.start_mul = 1'b1;
            step_in       = STEP_W'(QUOT_W - 1);
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- rtl/core/efp_datapath.sv -----
module efp_datapath #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [efp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [efp_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                 req_command,
   input  logic [7:0]                           req_data_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_channel,
   output logic signed [23:0]                   rsp_raw_sample,
   output logic signed [9:0]                    rsp_scaled_value,
   output logic                                 rsp_frame_last,
   output logic                                 rsp_ready_flag,
   input  efp_pkg::efp_cmd_type                 cmd,
   output efp_pkg::efp_stat_type                stat
);
   import efp_pkg::*;

   localparam int CHAN_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

   // configuration
   logic [7:0]  header_ff, init_ff;
   logic [3:0]  chcnt_ff;
   logic [15:0] fill_ff;
   logic [4:0]  gain_ff;

   // parser state
   logic              synced_ff, synced_in;
   logic [1:0]        init_run_ff, init_run_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [1:0]        byte_ff, byte_in;
   logic [15:0]       asm_ff, asm_in;
   logic [16:0]       fc_ff, fc_in;
   logic              ready_ff, ready_in;

   // sample held for scaling
   logic [2:0]         h_chan_ff, h_chan_in;
   logic signed [23:0] h_raw_ff, h_raw_in;
   logic               h_last_ff, h_last_in;
   logic               h_ready_ff, h_ready_in;

   // divider
   logic [NUM_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [QUOT_W-1:0] quot_ff;

   logic              rsp_valid_ff;

   logic [4:0]  ch_eff, ch_cfg, chan_next;
   logic        last;
   logic [4:0]  gain_eff;

   assign ch_cfg    = {1'b0, chcnt_ff};
   assign ch_eff    = (ch_cfg == '0) ? 5'd1 : ((ch_cfg > MAX_CH) ? MAX_CH : ch_cfg);
   assign chan_next = 5'(chan_ff) + 5'd1;
   assign last      = (chan_next >= ch_eff);
   assign gain_eff  = (gain_ff == '0) ? 5'd1 : gain_ff;

   assign stat.sample_now = !req_command && synced_ff && (phase_ff == PHASE_SAMPLE)
                            && (byte_ff == 2'd2);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;

   always_comb begin
      synced_in   = synced_ff;
      init_run_in = init_run_ff;
      phase_in    = phase_ff;
      chan_in     = chan_ff;
      byte_in     = byte_ff;
      asm_in      = asm_ff;
      fc_in       = fc_ff;
      ready_in    = ready_ff;
      h_chan_in   = h_chan_ff;
      h_raw_in    = h_raw_ff;
      h_last_in   = h_last_ff;
      h_ready_in  = h_ready_ff;
      if (req_command) begin
         ready_in = 1'b0;
         fc_in    = '0;
      end else if (!synced_ff) begin
         if (req_data_byte == init_ff) begin
            if (init_run_ff == 2'd2) begin
               synced_in   = 1'b1;
               init_run_in = '0;
               phase_in    = PHASE_HUNT;
            end else begin
               init_run_in = init_run_ff + 1'b1;
            end
         end else begin
            init_run_in = '0;
         end
      end else begin
         case (phase_ff)
            PHASE_HUNT: begin
               if (req_data_byte == header_ff) begin
                  phase_in = PHASE_SKIP;
                  if (fc_ff != FRAME_COUNT_MAX) begin
                     fc_in = fc_ff + 1'b1;
                  end
               end
            end
            PHASE_SKIP: begin
               phase_in = PHASE_SAMPLE;
               chan_in  = '0;
               byte_in  = '0;
               asm_in   = '0;
            end
            PHASE_SAMPLE: begin
               if (byte_ff != 2'd2) begin
                  asm_in  = {asm_ff[7:0], req_data_byte};
                  byte_in = byte_ff + 1'b1;
               end else begin
                  if (last && !ready_ff && (fc_ff > {1'b0, fill_ff})) begin
                     ready_in = 1'b1;
                     fc_in    = '0;
                  end
                  h_chan_in  = 3'(5'(chan_ff));
                  h_raw_in   = {asm_ff, req_data_byte};
                  h_last_in  = last;
                  h_ready_in = ready_in;
                  byte_in    = '0;
                  asm_in     = '0;
                  if (last) begin
                     phase_in = PHASE_HUNT;
                     chan_in  = '0;
                  end else begin
                     chan_in = CHAN_W'(chan_next);
                  end
               end
            end
            default: begin
               phase_in = PHASE_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= RST_HEADER_BYTE;
         init_ff   <= RST_INIT_BYTE;
         chcnt_ff  <= RST_CHANNEL_COUNT;
         fill_ff   <= RST_FILL_LENGTH;
         gain_ff   <= RST_AMP_GAIN;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_HEADER_BYTE:   header_ff <= csr_write_data[7:0];
            REG_INIT_BYTE:     init_ff   <= csr_write_data[7:0];
            REG_CHANNEL_COUNT: chcnt_ff  <= csr_write_data[3:0];
            REG_FILL_LENGTH:   fill_ff   <= csr_write_data[15:0];
            REG_AMP_GAIN:      gain_ff   <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff   <= 1'b0;
         init_run_ff <= '0;
         phase_ff    <= PHASE_HUNT;
         chan_ff     <= '0;
         byte_ff     <= '0;
         asm_ff      <= '0;
         fc_ff       <= '0;
         ready_ff    <= 1'b0;
      end else if (cmd.accept) begin
         synced_ff   <= synced_in;
         init_run_ff <= init_run_in;
         phase_ff    <= phase_in;
         chan_ff     <= chan_in;
         byte_ff     <= byte_in;
         asm_ff      <= asm_in;
         fc_ff       <= fc_in;
         ready_ff    <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         h_chan_ff  <= h_chan_in;
         h_raw_ff   <= h_raw_in;
         h_last_ff  <= h_last_in;
         h_ready_ff <= h_ready_in;
      end
   end

   // magnitude times 450 over gain times full scale, one quotient bit a step
   logic [23:0]       mag;
   logic [PROD_W-1:0] prod;
   logic [DEN_W-1:0]  rem_ext, diff;
   logic              ge;

   assign mag     = h_raw_ff[23] ? 24'(-h_raw_ff) : 24'(h_raw_ff);
   assign prod    = PROD_W'(gain_eff) * PROD_W'(FULL_SCALE);
   assign rem_ext = DEN_W'(rem_ff);
   assign ge      = (rem_ext >= den_ff);
   assign diff    = rem_ext - den_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_mul) begin
         rem_ff  <= NUM_W'(NUM_W'(mag) * NUM_W'(SCALE_NUM));
         den_ff  <= {prod, {(QUOT_W-1){1'b0}}};
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (ge) begin
            rem_ff <= diff[NUM_W-1:0];
         end
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
         den_ff  <= den_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_channel      <= h_chan_ff;
         rsp_raw_sample   <= h_raw_ff;
         rsp_scaled_value <= h_raw_ff[23] ? -$signed({1'b0, quot_ff})
                                          : $signed({1'b0, quot_ff});
         rsp_frame_last   <= h_last_ff;
         rsp_ready_flag   <= h_ready_ff;
      end
   end

endmodule

// ----- rtl/core/eeg_sample_frame_parser_core.sv -----
// eeg sample frame parser: takes one stream byte (or a clear command) per req_ transaction,
// locks on three consecutive init bytes, then per frame hunts the header byte, skips the
// sample-number byte and assembles big-endian 24-bit samples. every completed sample yields
// one rsp_ transaction with its channel, raw value, raw*450/(gain*8388607) truncated toward
// zero, a last-of-frame mark and the data ready flag. a byte that completes no sample does
// not stall req_; one that completes a sample stalls it through the multiply state, the
// restoring divider that produces one quotient bit a cycle and the output register load,
// which waits while the previous result is still held there. configuration is written
// through the csr_ port; the user must do so only while the block is idle (not enforced).
module eeg_sample_frame_parser_core #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_write_enable,
   input  logic [efp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [efp_pkg::CSR_DATA_W-1:0]   csr_write_data,
   // byte stream in
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [7:0]                       req_data_byte,
   // samples out
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_channel,
   output logic signed [23:0]               rsp_raw_sample,
   output logic signed [9:0]                rsp_scaled_value,
   output logic                             rsp_frame_last,
   output logic                             rsp_ready_flag
);
   import efp_pkg::*;

   efp_cmd_type  cmd;
   efp_stat_type stat;

   // sequencer: accept, multiply, divide, hand over to the output register
   efp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // parser state, frame counter, scaling arithmetic and output register
   efp_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel      (rsp_channel),
      .rsp_raw_sample   (rsp_raw_sample),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_ready_flag   (rsp_ready_flag),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
